FILE: src/hmtp_pkg.sv
`default_nettype none
package hmtp_pkg;

    localparam int INDEX_BITS = 16;

    typedef logic [INDEX_BITS-1:0] index_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;

    localparam logic [31:0] DEFAULT_COLOR_RESET = 32'h00FF_FFFF;

    typedef enum logic
    {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic       kind;
        logic [7:0] ch;
    } item_t;

    typedef struct packed
    {
        logic [15:0]        row;
        logic [15:0]        col;
        logic signed [31:0] height;
        logic [31:0]        color;
        logic               color_given;
        logic               bad_value;
    } point_t;

endpackage
`default_nettype wire

FILE: src/hmtp_if.sv
`default_nettype none
interface hmtp_char_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink (input valid, input kind, input ch, output ready);
endinterface

interface hmtp_point_if;
    logic               valid;
    logic               ready;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] height;
    logic [31:0]        color;
    logic               color_given;
    logic               bad_value;

    modport source (output valid, output row, output col, output height, output color,
                    output color_given, output bad_value, input ready);
    modport sink (input valid, input row, input col, input height, input color,
                  input color_given, input bad_value, output ready);
endinterface
`default_nettype wire

FILE: src/hmtp_acc.sv
`default_nettype none
module hmtp_acc
(
    input  wire logic signed [31:0] height_acc,
    input  wire logic               negative,
    input  wire logic [31:0]        color_acc,
    input  wire logic               hex_mode,
    input  wire logic [3:0]         digit,
    output logic [31:0]             height_sum,
    output logic                    height_ovf,
    output logic [31:0]             color_sum,
    output logic                    color_ovf
);

    logic signed [36:0] cur_x;
    logic signed [36:0] prod;
    logic signed [36:0] dig;
    logic signed [36:0] dig_s;
    logic signed [36:0] hsum;
    logic [36:0]        cx;
    logic [36:0]        cprod;
    logic [36:0]        csum;

    // height: acc*10 +/- digit, signed 32-bit range check
    always_comb
    begin
        cur_x = 37'(height_acc);
        prod  = (cur_x <<< 3) + (cur_x <<< 1);
        dig   = $signed({33'd0, digit});
        dig_s = negative ? -dig : dig;
        hsum  = prod + dig_s;
        height_sum = hsum[31:0];
        height_ovf = (hsum[36:31] != {6{hsum[31]}});
    end

    // color: acc*16 or acc*10 + digit, unsigned 32-bit range check
    always_comb
    begin
        cx    = {5'd0, color_acc};
        cprod = hex_mode ? (cx << 4) : ((cx << 3) + (cx << 1));
        csum  = cprod + {33'd0, digit};
        color_sum = csum[31:0];
        color_ovf = |csum[36:32];
    end

endmodule
`default_nettype wire

FILE: src/hmtp_core.sv
`default_nettype none
module hmtp_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire hmtp_pkg::item_t item,
    input  wire logic [31:0]    default_color,
    output logic                fire,
    output hmtp_pkg::point_t    point
);

    typedef enum logic [2:0]
    {
        PH_IDLE     = 3'd0,
        PH_H_START  = 3'd1,
        PH_H_DIGITS = 3'd2,
        PH_C_START  = 3'd3,
        PH_C_ZERO   = 3'd4,
        PH_C_DIGITS = 3'd5,
        PH_SKIP     = 3'd6
    } phase_t;

    phase_t               phase_reg, phase_next, ph_eff;
    hmtp_pkg::index_t     row_count_reg, row_count_next;
    hmtp_pkg::index_t     col_count_reg, col_count_next;
    hmtp_pkg::index_t     col_fin;
    logic signed [31:0]   height_acc_reg;
    logic [31:0]          height_acc_next;
    logic                 negative_reg, negative_next;
    logic [31:0]          color_acc_reg, color_acc_next;
    logic                 hex_mode_reg, hex_mode_next;
    logic                 token_error_reg, token_error_next;
    logic                 halted_reg, halted_next;
    logic                 color_seen_reg, color_seen_next;

    logic                 is_inner, is_dec, is_hex, is_x;
    logic [3:0]           digit;
    logic [31:0]          height_sum, color_sum;
    logic                 height_ovf, color_ovf;
    logic                 finish;

    function automatic hmtp_pkg::index_t sat_inc(input hmtp_pkg::index_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    hmtp_acc u_acc
    (
        .height_acc (height_acc_reg),
        .negative   (negative_reg),
        .color_acc  (color_acc_reg),
        .hex_mode   (hex_mode_reg),
        .digit      (digit),
        .height_sum (height_sum),
        .height_ovf (height_ovf),
        .color_sum  (color_sum),
        .color_ovf  (color_ovf)
    );

    always_comb
    begin
        is_inner = (item.ch == hmtp_pkg::CH_TAB) || (item.ch == hmtp_pkg::CH_VTAB) ||
                   (item.ch == hmtp_pkg::CH_FFEED) || (item.ch == hmtp_pkg::CH_CR);
        is_dec   = (item.ch >= hmtp_pkg::CH_ZERO) && (item.ch <= hmtp_pkg::CH_NINE);
        is_hex   = is_dec ||
                   ((item.ch >= hmtp_pkg::CH_LO_A) && (item.ch <= hmtp_pkg::CH_LO_F)) ||
                   ((item.ch >= hmtp_pkg::CH_UP_A) && (item.ch <= hmtp_pkg::CH_UP_F));
        is_x     = (item.ch == hmtp_pkg::CH_LO_X) || (item.ch == hmtp_pkg::CH_UP_X);
        digit    = is_dec ? item.ch[3:0] : item.ch[3:0] + 4'd9;
    end

    assign fire = step && !halted_reg && finish && (phase_reg != PH_IDLE);

    always_comb
    begin
        point.row         = 16'(row_count_reg);
        point.col         = 16'(col_count_reg);
        point.height      = height_acc_reg;
        point.color       = color_seen_reg ? color_acc_reg : default_color;
        point.color_given = color_seen_reg;
        point.bad_value   = token_error_reg;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        row_count_next   = row_count_reg;
        col_count_next   = col_count_reg;
        height_acc_next  = height_acc_reg;
        negative_next    = negative_reg;
        color_acc_next   = color_acc_reg;
        hex_mode_next    = hex_mode_reg;
        token_error_next = token_error_reg;
        halted_next      = halted_reg;
        color_seen_next  = color_seen_reg;
        finish           = (item.kind == hmtp_pkg::KIND_END) ||
                           (item.ch == hmtp_pkg::CH_SPACE) || (item.ch == hmtp_pkg::CH_NEWLINE);
        ph_eff           = (phase_reg == PH_IDLE) ? PH_H_START : phase_reg;
        col_fin          = (phase_reg != PH_IDLE) ? sat_inc(col_count_reg) : col_count_reg;

        if (step && !halted_reg)
        begin
            if (finish)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    halted_next = token_error_reg;
                end
                col_count_next   = col_fin;
                phase_next       = PH_IDLE;
                height_acc_next  = '0;
                negative_next    = 1'b0;
                color_acc_next   = '0;
                hex_mode_next    = 1'b0;
                token_error_next = 1'b0;
                color_seen_next  = 1'b0;
                if ((item.kind == hmtp_pkg::KIND_END && col_fin != '0) ||
                    (item.kind == hmtp_pkg::KIND_CHAR && item.ch == hmtp_pkg::CH_NEWLINE))
                begin
                    row_count_next = sat_inc(row_count_reg);
                    col_count_next = '0;
                end
            end
            else
            begin
                phase_next = ph_eff;
                case (ph_eff)
                    PH_H_START:
                    begin
                        if (is_inner)
                        begin
                        end
                        else if (item.ch == hmtp_pkg::CH_MINUS)
                        begin
                            negative_next = 1'b1;
                            phase_next    = PH_H_DIGITS;
                        end
                        else if (item.ch == hmtp_pkg::CH_PLUS)
                        begin
                            phase_next = PH_H_DIGITS;
                        end
                        else if (is_dec)
                        begin
                            height_acc_next  = height_sum;
                            token_error_next = token_error_reg | height_ovf;
                            phase_next       = PH_H_DIGITS;
                        end
                        else if (item.ch == hmtp_pkg::CH_COMMA)
                        begin
                            phase_next = PH_C_START;
                        end
                        else
                        begin
                            token_error_next = 1'b1;
                            phase_next       = PH_SKIP;
                        end
                    end
                    PH_H_DIGITS:
                    begin
                        if (is_dec)
                        begin
                            height_acc_next  = height_sum;
                            token_error_next = token_error_reg | height_ovf;
                        end
                        else if (item.ch == hmtp_pkg::CH_COMMA)
                        begin
                            phase_next = PH_C_START;
                        end
                        else
                        begin
                            token_error_next = 1'b1;
                            phase_next       = PH_SKIP;
                        end
                    end
                    PH_C_START:
                    begin
                        color_seen_next = 1'b1;
                        if (is_inner)
                        begin
                        end
                        else if (item.ch == hmtp_pkg::CH_ZERO)
                        begin
                            phase_next = PH_C_ZERO;
                        end
                        else if (is_dec)
                        begin
                            color_acc_next   = color_sum;
                            token_error_next = token_error_reg | color_ovf;
                            phase_next       = PH_C_DIGITS;
                        end
                        else
                        begin
                            token_error_next = 1'b1;
                            phase_next       = PH_SKIP;
                        end
                    end
                    PH_C_ZERO:
                    begin
                        if (is_x)
                        begin
                            hex_mode_next = 1'b1;
                            phase_next    = PH_C_DIGITS;
                        end
                        else if (is_dec)
                        begin
                            color_acc_next   = color_sum;
                            token_error_next = token_error_reg | color_ovf;
                            phase_next       = PH_C_DIGITS;
                        end
                        else
                        begin
                            token_error_next = 1'b1;
                            phase_next       = PH_SKIP;
                        end
                    end
                    PH_C_DIGITS:
                    begin
                        if (is_dec || (is_hex && hex_mode_reg))
                        begin
                            color_acc_next   = color_sum;
                            token_error_next = token_error_reg | color_ovf;
                        end
                        else
                        begin
                            token_error_next = 1'b1;
                            phase_next       = PH_SKIP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            row_count_reg   <= '0;
            col_count_reg   <= '0;
            height_acc_reg  <= '0;
            negative_reg    <= 1'b0;
            color_acc_reg   <= '0;
            hex_mode_reg    <= 1'b0;
            token_error_reg <= 1'b0;
            halted_reg      <= 1'b0;
            color_seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            height_acc_reg  <= $signed(height_acc_next);
            negative_reg    <= negative_next;
            color_acc_reg   <= color_acc_next;
            hex_mode_reg    <= hex_mode_next;
            token_error_reg <= token_error_next;
            halted_reg      <= halted_next;
            color_seen_reg  <= color_seen_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/height_map_token_parser_top.sv
`default_nettype none
// Height-map token parser: takes map text one character per transfer on chars and gives
// one point per token on points. Throughput is one character per cycle while no point
// is held up on points; the space, newline or end-of-input item that closes a token is
// registered in the input register and its point then in the point register. The rate
// is set by the token state update, a combinational constant multiply-add with range
// check on the height or color accumulator. After a bad point the block keeps taking
// input but gives nothing until reset. cfg_we/cfg_data write the default color.
module height_map_token_parser_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    hmtp_char_if.sink         chars,
    hmtp_point_if.source      points,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_data
);

    logic              in_vld_reg, in_vld_next;
    hmtp_pkg::item_t   item_reg;
    logic              out_vld_reg, out_vld_next;
    hmtp_pkg::point_t  pt_reg;
    logic [31:0]       default_color_reg;
    logic              step;
    logic              fire;
    hmtp_pkg::point_t  point;

    assign step         = in_vld_reg && (!out_vld_reg || points.ready);
    assign chars.ready  = !in_vld_reg || step;
    assign in_vld_next  = chars.valid ? 1'b1 : (step ? 1'b0 : in_vld_reg);
    assign out_vld_next = fire ? 1'b1 : (points.ready ? 1'b0 : out_vld_reg);

    hmtp_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (item_reg),
        .default_color (default_color_reg),
        .fire          (fire),
        .point         (point)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
            default_color_reg <= hmtp_pkg::DEFAULT_COLOR_RESET;
        end
        else
        begin
            if (chars.ready)
            begin
                in_vld_reg <= in_vld_next;
            end
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                default_color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            item_reg.kind <= chars.kind;
            item_reg.ch   <= chars.ch;
        end
        if (fire)
        begin
            pt_reg <= point;
        end
    end

    assign points.valid       = out_vld_reg;
    assign points.row         = pt_reg.row;
    assign points.col         = pt_reg.col;
    assign points.height      = pt_reg.height;
    assign points.color       = pt_reg.color;
    assign points.color_given = pt_reg.color_given;
    assign points.bad_value   = pt_reg.bad_value;

endmodule
`default_nettype wire
